// ===== rtl/lpfp_pkg.sv =====
// Shared types and constants of the lidar packet field parser.
`default_nettype none
package lpfp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_UNIT      = 3'd0,
    KIND_OK        = 3'd1,
    KIND_BAD_MARK  = 3'd2,
    KIND_BAD_LEN   = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_t;

  // Packet section being parsed
  typedef enum logic [2:0] {
    SEC_HEADER = 3'd0,
    SEC_AZIM   = 3'd1,
    SEC_UNIT   = 3'd2,
    SEC_TAIL   = 3'd3,
    SEC_DONE   = 3'd4,
    SEC_SKIP   = 3'd5
  } section_t;

  // Register indexes
  localparam logic REG_FULL_LENGTH  = 1'b0;
  localparam logic REG_SHORT_LENGTH = 1'b1;

  localparam int unsigned LEN_W    = 11;
  localparam int unsigned POS_W    = 12;
  localparam logic [POS_W-1:0] POS_LIMIT = 12'd2048;

  localparam logic [LEN_W-1:0] FULL_LENGTH_RST  = 11'd1072;
  localparam logic [LEN_W-1:0] SHORT_LENGTH_RST = 11'd1068;

  localparam logic [15:0] START_MARK = 16'hEEFF;
  localparam logic [7:0]  YEAR_BASE  = 8'd100;

  // Header byte offsets
  localparam int unsigned HDR_LASERS   = 6;
  localparam int unsigned HDR_BLOCKS   = 7;
  localparam int unsigned HDR_RET_TYPE = 8;
  localparam int unsigned HDR_UNIT     = 9;

  // Defaults of the layout parameters
  localparam int unsigned HEADER_BYTES_DEF   = 12;
  localparam int unsigned MAX_BLOCKS_DEF     = 4;
  localparam int unsigned MAX_LASERS_DEF     = 64;
  localparam int unsigned RESERVED_BYTES_DEF = 10;
  localparam int unsigned SPEED_BYTES_DEF    = 2;
  localparam int unsigned FACTORY_BYTES_DEF  = 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One parsed event handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  block_index;
    logic [5:0]  laser_index;
    logic [15:0] azimuth;
    logic [15:0] range_raw;
    logic [7:0]  dist_unit;
    logic [7:0]  intensity;
    logic [7:0]  confidence;
    logic [7:0]  return_type;
    logic [31:0] microseconds;
    logic [7:0]  echo_mode;
    logic [47:0] utc_raw;
    logic [2:0]  utc_got;
  } event_t;

endpackage
`default_nettype wire

// ===== rtl/lpfp_cfg.sv =====
// APB register file holding the accepted packet lengths.
`default_nettype none
module lpfp_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [lpfp_pkg::LEN_W-1:0] full_length,
  output logic      [lpfp_pkg::LEN_W-1:0] short_length
);
  import lpfp_pkg::*;

  logic [LEN_W-1:0] full_len_r;
  logic [LEN_W-1:0] short_len_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_len_r  <= FULL_LENGTH_RST;
      short_len_r <= SHORT_LENGTH_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_FULL_LENGTH) begin
        full_len_r <= pwdata[LEN_W-1:0];
      end else begin
        short_len_r <= pwdata[LEN_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SHORT_LENGTH) begin
      prdata[LEN_W-1:0] = short_len_r;
    end else begin
      prdata[LEN_W-1:0] = full_len_r;
    end
  end

  assign full_length  = full_len_r;
  assign short_length = short_len_r;

endmodule
`default_nettype wire

// ===== rtl/lpfp_front.sv =====
// Front end: walks the packet byte by byte and classifies it into events.
`default_nettype none
module lpfp_front #(
  parameter int unsigned HEADER_BYTES   = lpfp_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS     = lpfp_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_LASERS     = lpfp_pkg::MAX_LASERS_DEF,
  parameter int unsigned RESERVED_BYTES = lpfp_pkg::RESERVED_BYTES_DEF,
  parameter int unsigned SPEED_BYTES    = lpfp_pkg::SPEED_BYTES_DEF,
  parameter int unsigned FACTORY_BYTES  = lpfp_pkg::FACTORY_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_last_byte,
  input  wire logic [lpfp_pkg::LEN_W-1:0] full_length,
  input  wire logic [lpfp_pkg::LEN_W-1:0] short_length,
  input  wire logic                       q_full,
  output logic                            ev_push,
  output lpfp_pkg::event_t                ev
);
  import lpfp_pkg::*;

  localparam int unsigned USEC_AT    = RESERVED_BYTES + SPEED_BYTES;
  localparam int unsigned ECHO_AT    = USEC_AT + 4;
  localparam int unsigned UTC_AT     = ECHO_AT + 1 + FACTORY_BYTES;
  localparam int unsigned TAIL_BYTES = UTC_AT + 6;
  localparam int unsigned TW         = $clog2(TAIL_BYTES + 1);

  section_t         sec_r, sec_step, sec_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      mark_r, mark_nxt;
  logic [7:0]       lt_r, lt_nxt;
  logic [7:0]       bt_r, bt_nxt;
  logic [7:0]       unit_r, unit_nxt;
  logic [7:0]       rtype_r, rtype_nxt;
  kind_t            err_r, err_nxt;
  logic [2:0]       blk_r, blk_nxt;
  logic [5:0]       las_r, las_nxt;
  logic [1:0]       fb_r, fb_nxt;
  logic [15:0]      az_r, az_nxt;
  logic [15:0]      rng_r, rng_nxt;
  logic [7:0]       inten_r, inten_nxt;
  logic [31:0]      usec_r, usec_nxt;
  logic [7:0]       echo_r, echo_nxt;
  logic [47:0]      utc_r, utc_nxt;
  logic [TW-1:0]    tail_r, tail_nxt;
  logic [TW-1:0]    usec_off;
  logic [TW-1:0]    utc_diff;
  logic             acc;
  logic             hdr_end;
  logic             too_large;
  logic             blk_last;
  logic             las_last;
  logic             unit_emit;

  assign in_stall  = q_full;
  assign acc       = in_valid && !in_stall;
  assign hdr_end   = (pos_r == POS_W'(HEADER_BYTES - 1));
  assign too_large = (bt_r > 8'(MAX_BLOCKS)) || (lt_r > 8'(MAX_LASERS));
  assign blk_last  = (({5'b0, blk_r} + 8'd1) >= bt_r);
  assign las_last  = (({2'b0, las_r} + 8'd1) >= lt_r);
  assign usec_off  = tail_r - TW'(USEC_AT);

  // section next state
  always_comb begin
    sec_step = sec_r;
    unique case (sec_r)
      SEC_HEADER: begin
        if (hdr_end) begin
          if (mark_r != START_MARK || too_large) begin
            sec_step = SEC_SKIP;
          end else if (bt_r == 8'd0) begin
            sec_step = SEC_TAIL;
          end else begin
            sec_step = SEC_AZIM;
          end
        end
      end
      SEC_AZIM: begin
        if (fb_r != 2'd0) begin
          if (lt_r != 8'd0) begin
            sec_step = SEC_UNIT;
          end else begin
            sec_step = blk_last ? SEC_TAIL : SEC_AZIM;
          end
        end
      end
      SEC_UNIT: begin
        if (fb_r == 2'd3 && las_last) begin
          sec_step = blk_last ? SEC_TAIL : SEC_AZIM;
        end
      end
      SEC_TAIL: begin
        if ((tail_r + TW'(1)) >= TW'(TAIL_BYTES)) begin
          sec_step = SEC_DONE;
        end
      end
      SEC_DONE, SEC_SKIP: sec_step = sec_r;
      default: sec_step = SEC_HEADER;
    endcase
    sec_nxt = in_last_byte ? SEC_HEADER : sec_step;
  end

  // field capture, counters and event build
  always_comb begin
    pos_nxt   = (pos_r < POS_LIMIT) ? pos_r + POS_W'(1) : pos_r;
    mark_nxt  = mark_r;
    lt_nxt    = lt_r;
    bt_nxt    = bt_r;
    unit_nxt  = unit_r;
    rtype_nxt = rtype_r;
    err_nxt   = err_r;
    blk_nxt   = blk_r;
    las_nxt   = las_r;
    fb_nxt    = fb_r;
    az_nxt    = az_r;
    rng_nxt   = rng_r;
    inten_nxt = inten_r;
    usec_nxt  = usec_r;
    echo_nxt  = echo_r;
    utc_nxt   = utc_r;
    tail_nxt  = tail_r;
    unit_emit = 1'b0;
    utc_diff  = '0;
    ev        = '0;

    unique case (sec_r)
      SEC_HEADER: begin
        if (pos_r == POS_W'(0)) begin
          mark_nxt = {in_data_byte, 8'd0};
        end else if (pos_r == POS_W'(1)) begin
          mark_nxt[7:0] = in_data_byte;
        end else if (pos_r == POS_W'(HDR_LASERS)) begin
          lt_nxt = in_data_byte;
        end else if (pos_r == POS_W'(HDR_BLOCKS)) begin
          bt_nxt = in_data_byte;
        end else if (pos_r == POS_W'(HDR_RET_TYPE)) begin
          rtype_nxt = in_data_byte;
        end else if (pos_r == POS_W'(HDR_UNIT)) begin
          unit_nxt = in_data_byte;
        end
        if (hdr_end) begin
          if (mark_r != START_MARK) begin
            err_nxt = KIND_BAD_MARK;
          end else if (too_large) begin
            err_nxt = KIND_TOO_LARGE;
          end else if (bt_r != 8'd0) begin
            blk_nxt = 3'd0;
            fb_nxt  = 2'd0;
          end
        end
      end
      SEC_AZIM: begin
        if (fb_r == 2'd0) begin
          az_nxt = {8'd0, in_data_byte};
          fb_nxt = 2'd1;
        end else begin
          az_nxt[15:8] = in_data_byte;
          fb_nxt       = 2'd0;
          las_nxt      = 6'd0;
          if (lt_r == 8'd0 && !blk_last) begin
            blk_nxt = blk_r + 3'd1;
          end
        end
      end
      SEC_UNIT: begin
        unique case (fb_r)
          2'd0: begin
            rng_nxt = {8'd0, in_data_byte};
            fb_nxt  = 2'd1;
          end
          2'd1: begin
            rng_nxt[15:8] = in_data_byte;
            fb_nxt        = 2'd2;
          end
          2'd2: begin
            inten_nxt = in_data_byte;
            fb_nxt    = 2'd3;
          end
          default: begin
            unit_emit      = 1'b1;
            ev.kind        = KIND_UNIT;
            ev.block_index = blk_r;
            ev.laser_index = las_r;
            ev.azimuth     = az_r;
            ev.range_raw   = rng_r;
            ev.dist_unit   = unit_r;
            ev.intensity   = inten_r;
            ev.confidence  = in_data_byte;
            fb_nxt         = 2'd0;
            if (las_last) begin
              las_nxt = 6'd0;
              if (!blk_last) begin
                blk_nxt = blk_r + 3'd1;
              end
            end else begin
              las_nxt = las_r + 6'd1;
            end
          end
        endcase
      end
      SEC_TAIL: begin
        if (tail_r >= TW'(USEC_AT) && tail_r < TW'(ECHO_AT)) begin
          usec_nxt[8*usec_off[1:0] +: 8] = in_data_byte;
        end else if (tail_r == TW'(ECHO_AT)) begin
          echo_nxt = in_data_byte;
        end else if (tail_r >= TW'(UTC_AT) && tail_r < TW'(TAIL_BYTES)) begin
          utc_nxt = {utc_r[39:0], in_data_byte};
        end
        tail_nxt = tail_r + TW'(1);
      end
      SEC_DONE, SEC_SKIP: begin
        tail_nxt = tail_r;
      end
      default: begin
        tail_nxt = tail_r;
      end
    endcase

    // end of packet: trailer or error replaces any unit record
    if (in_last_byte) begin
      ev = '0;
      if (pos_nxt != {1'b0, full_length} && pos_nxt != {1'b0, short_length}) begin
        ev.kind = KIND_BAD_LEN;
      end else if (sec_step == SEC_HEADER) begin
        ev.kind = KIND_BAD_MARK;
      end else if (sec_step == SEC_SKIP) begin
        ev.kind = err_nxt;
      end else begin
        ev.kind         = KIND_OK;
        ev.return_type  = rtype_nxt;
        ev.microseconds = usec_nxt;
        ev.echo_mode    = echo_nxt;
        ev.utc_raw      = utc_nxt;
        utc_diff        = tail_nxt - TW'(UTC_AT);
        if (tail_nxt <= TW'(UTC_AT)) begin
          ev.utc_got = 3'd0;
        end else if (utc_diff > TW'(6)) begin
          ev.utc_got = 3'd6;
        end else begin
          ev.utc_got = utc_diff[2:0];
        end
      end
      pos_nxt   = '0;
      mark_nxt  = '0;
      lt_nxt    = '0;
      bt_nxt    = '0;
      unit_nxt  = '0;
      rtype_nxt = '0;
      err_nxt   = KIND_UNIT;
      blk_nxt   = '0;
      las_nxt   = '0;
      fb_nxt    = '0;
      az_nxt    = '0;
      rng_nxt   = '0;
      inten_nxt = '0;
      usec_nxt  = '0;
      echo_nxt  = '0;
      utc_nxt   = '0;
      tail_nxt  = '0;
    end
  end

  assign ev_push = acc && (in_last_byte || unit_emit);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= SEC_HEADER;
      pos_r   <= '0;
      mark_r  <= '0;
      lt_r    <= '0;
      bt_r    <= '0;
      unit_r  <= '0;
      rtype_r <= '0;
      err_r   <= KIND_UNIT;
      blk_r   <= '0;
      las_r   <= '0;
      fb_r    <= '0;
      az_r    <= '0;
      rng_r   <= '0;
      inten_r <= '0;
      usec_r  <= '0;
      echo_r  <= '0;
      utc_r   <= '0;
      tail_r  <= '0;
    end else if (acc) begin
      sec_r   <= sec_nxt;
      pos_r   <= pos_nxt;
      mark_r  <= mark_nxt;
      lt_r    <= lt_nxt;
      bt_r    <= bt_nxt;
      unit_r  <= unit_nxt;
      rtype_r <= rtype_nxt;
      err_r   <= err_nxt;
      blk_r   <= blk_nxt;
      las_r   <= las_nxt;
      fb_r    <= fb_nxt;
      az_r    <= az_nxt;
      rng_r   <= rng_nxt;
      inten_r <= inten_nxt;
      usec_r  <= usec_nxt;
      echo_r  <= echo_nxt;
      utc_r   <= utc_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpfp_queue.sv =====
// Small event queue between the parser front and the output back end.
`default_nettype none
module lpfp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lpfp_pkg::event_t push_ev,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output lpfp_pkg::event_t      head_ev
);
  import lpfp_pkg::*;

  event_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head_ev   = slot_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ev;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpfp_back.sv =====
// Back end: scales the range, aligns the UTC bytes and holds the result register.
`default_nettype none
module lpfp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  wire lpfp_pkg::event_t q_ev,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [2:0]       out_kind,
  output logic      [2:0]       out_block_index,
  output logic      [5:0]       out_laser_index,
  output logic      [15:0]      out_azimuth,
  output logic      [23:0]      out_range_mm,
  output logic      [7:0]       out_intensity,
  output logic      [7:0]       out_confidence,
  output logic      [7:0]       out_return_type,
  output logic      [31:0]      out_microseconds,
  output logic      [7:0]       out_echo_mode,
  output logic      [47:0]      out_utc_packed
);
  import lpfp_pkg::*;

  logic        valid_r;
  logic [2:0]  kind_r;
  logic [2:0]  blk_r;
  logic [5:0]  las_r;
  logic [15:0] az_r;
  logic [23:0] range_r;
  logic [7:0]  inten_r;
  logic [7:0]  conf_r;
  logic [7:0]  rtype_r;
  logic [31:0] usec_r;
  logic [7:0]  echo_r;
  logic [47:0] utc_r;
  logic [23:0] range_mm;
  logic [47:0] utc_al;
  logic [7:0]  year;
  logic [47:0] utc_fix;

  assign q_pop = q_not_empty && (!valid_r || !out_stall);

  // range scaling, 16 x 8, full 24-bit product
  assign range_mm = {8'd0, q_ev.range_raw} * {16'd0, q_ev.dist_unit};

  // left-align the UTC bytes that arrived, then fix the year base
  always_comb begin
    unique case (q_ev.utc_got)
      3'd1:    utc_al = {q_ev.utc_raw[7:0],  40'd0};
      3'd2:    utc_al = {q_ev.utc_raw[15:0], 32'd0};
      3'd3:    utc_al = {q_ev.utc_raw[23:0], 24'd0};
      3'd4:    utc_al = {q_ev.utc_raw[31:0], 16'd0};
      3'd5:    utc_al = {q_ev.utc_raw[39:0], 8'd0};
      3'd6:    utc_al = q_ev.utc_raw;
      default: utc_al = '0;
    endcase
    year = utc_al[47:40];
    if (q_ev.utc_got != 3'd0 && year < YEAR_BASE) begin
      year = year + YEAR_BASE;
    end
    utc_fix = {year, utc_al[39:0]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= q_ev.kind;
      blk_r   <= q_ev.block_index;
      las_r   <= q_ev.laser_index;
      az_r    <= q_ev.azimuth;
      range_r <= range_mm;
      inten_r <= q_ev.intensity;
      conf_r  <= q_ev.confidence;
      rtype_r <= q_ev.return_type;
      usec_r  <= q_ev.microseconds;
      echo_r  <= q_ev.echo_mode;
      utc_r   <= utc_fix;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_block_index  = blk_r;
  assign out_laser_index  = las_r;
  assign out_azimuth      = az_r;
  assign out_range_mm     = range_r;
  assign out_intensity    = inten_r;
  assign out_confidence   = conf_r;
  assign out_return_type  = rtype_r;
  assign out_microseconds = usec_r;
  assign out_echo_mode    = echo_r;
  assign out_utc_packed   = utc_r;

endmodule
`default_nettype wire

// ===== rtl/lidar_packet_field_parser.sv =====
// Lidar packet field parser: byte stream in, unit records and trailers out.
//
// Input channel: one packet byte per transaction (in_data_byte), with
// in_last_byte set on the final byte. Output channel: one result per
// transaction: a unit record per completed laser unit, and on the last byte
// either a packet-ok trailer or an error kind. Both channels use valid/stall.
// APB port: full_length at address 0, short_length at address 4.
// Throughput: one byte per cycle while in_stall is low, set by the single-byte parser step.
// Path: a result is written into the event queue when its byte is accepted,
// and moves from there into the output register when that register is free.
// A 4-entry event queue sits between the parser and the output register;
// while the receiver stalls, bytes are still accepted until the queue fills,
// then in_stall rises. The output register holds its value while stalled.
// Reset (synchronous, active low) empties the queue, drops out_valid, puts the
// parser at the start of a packet and loads the length registers with
// 1072 and 1068.
`default_nettype none
module lidar_packet_field_parser #(
  parameter int unsigned HEADER_BYTES   = lpfp_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS     = lpfp_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_LASERS     = lpfp_pkg::MAX_LASERS_DEF,
  parameter int unsigned RESERVED_BYTES = lpfp_pkg::RESERVED_BYTES_DEF,
  parameter int unsigned SPEED_BYTES    = lpfp_pkg::SPEED_BYTES_DEF,
  parameter int unsigned FACTORY_BYTES  = lpfp_pkg::FACTORY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  out_kind,
  output logic      [2:0]  out_block_index,
  output logic      [5:0]  out_laser_index,
  output logic      [15:0] out_azimuth,
  output logic      [23:0] out_range_mm,
  output logic      [7:0]  out_intensity,
  output logic      [7:0]  out_confidence,
  output logic      [7:0]  out_return_type,
  output logic      [31:0] out_microseconds,
  output logic      [7:0]  out_echo_mode,
  output logic      [47:0] out_utc_packed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import lpfp_pkg::*;

  logic [LEN_W-1:0] full_length;
  logic [LEN_W-1:0] short_length;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             ev_push;
  event_t           ev;
  event_t           head_ev;

  lpfp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .full_length  (full_length),
    .short_length (short_length)
  );

  lpfp_front #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MAX_LASERS     (MAX_LASERS),
    .RESERVED_BYTES (RESERVED_BYTES),
    .SPEED_BYTES    (SPEED_BYTES),
    .FACTORY_BYTES  (FACTORY_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .full_length  (full_length),
    .short_length (short_length),
    .q_full       (q_full),
    .ev_push      (ev_push),
    .ev           (ev)
  );

  lpfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_ev   (ev),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_ev   (head_ev)
  );

  lpfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_ev             (head_ev),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_block_index  (out_block_index),
    .out_laser_index  (out_laser_index),
    .out_azimuth      (out_azimuth),
    .out_range_mm     (out_range_mm),
    .out_intensity    (out_intensity),
    .out_confidence   (out_confidence),
    .out_return_type  (out_return_type),
    .out_microseconds (out_microseconds),
    .out_echo_mode    (out_echo_mode),
    .out_utc_packed   (out_utc_packed)
  );

endmodule
`default_nettype wire
